>>> rtl/psfpg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the fringe generator.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package psfpg_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int PHASE_BITS = 24;
    localparam int TABLE_BITS = 10;
    localparam int QSIZE      = 1 << (TABLE_BITS - 2);

    localparam int SIDE_BITS  = $clog2(MAX_SIDE);          // counter width
    localparam int SIZE_BITS  = 13;                        // size register width
    localparam int POS_BITS   = SIDE_BITS;
    localparam int ADDR_BITS  = TABLE_BITS - 1;            // quarter table address
    localparam int SINE_BITS  = 17;                        // Q16, up to 1.0
    localparam int LEVEL_BITS = SINE_BITS + 1;             // s + 1.0, 0 .. 2.0
    localparam int GAIN_BITS  = 9;                         // 256 - min_brightness

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [SINE_BITS-1:0] Q16_ONE = SINE_BITS'(65536);

    localparam logic [1:0] FRAME_SINE   = 2'd0;
    localparam logic [1:0] FRAME_COSINE = 2'd1;
    localparam logic [1:0] FRAME_FLAT   = 2'd2;
    localparam logic [1:0] FRAME_COUNT  = 2'd3;

    typedef enum logic [2:0] {
        REG_ORIENTATION    = 3'd0,
        REG_PHASE_STEP     = 3'd1,
        REG_MIN_BRIGHTNESS = 3'd2,
        REG_FRAME_WIDTH    = 3'd3,
        REG_FRAME_HEIGHT   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic                  orientation;
        logic [PHASE_BITS-1:0] phase_step;
        logic [7:0]            min_brightness;
        logic [SIZE_BITS-1:0]  frame_width;
        logic [SIZE_BITS-1:0]  frame_height;
    } cfg_t;

    // one classified pixel, passed from the scan counters to the shading pipe
    typedef struct packed {
        logic [SIDE_BITS-1:0] column;
        logic [SIDE_BITS-1:0] row;
        logic [1:0]           frame;
        logic                 eof;
        logic                 eos;
    } pixel_word_t;

    typedef logic [SINE_BITS-1:0] sine_table_t [0:QSIZE];

    function automatic logic [63:0] taylor_power(input logic [63:0] term,
                                                 input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Q30 Taylor series, eight terms, rounded to Q16 and capped at 1.0
    function automatic sine_table_t build_sine_table();
        sine_table_t        tbl;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        r;
        for (int q = 0; q <= QSIZE; q++)
        begin
            x    = (64'(q) * HALF_PI_Q30) / QSIZE;
            term = x;
            acc  = $signed(x);
            term = taylor_power(term, x) / 64'd6;   acc = acc - $signed(term);
            term = taylor_power(term, x) / 64'd20;  acc = acc + $signed(term);
            term = taylor_power(term, x) / 64'd42;  acc = acc - $signed(term);
            term = taylor_power(term, x) / 64'd72;  acc = acc + $signed(term);
            term = taylor_power(term, x) / 64'd110; acc = acc - $signed(term);
            term = taylor_power(term, x) / 64'd156; acc = acc + $signed(term);
            term = taylor_power(term, x) / 64'd210; acc = acc - $signed(term);
            if (acc < 0)
            begin
                acc = 64'sd0;
            end
            r = ($unsigned(acc) + 64'd8192) >> 14;
            if (r > 64'd65536)
            begin
                r = 64'd65536;
            end
            tbl[q] = r[SINE_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

>>> rtl/phase_shift_fringe_pattern_generator.sv
// Three-frame phase-shift fringe generator: sine, cosine and flat frames in raster order.
// An accepted word is held in the queue, then passes the a, b and output registers of the shading pipe.
// Throughput: one pixel per cycle while the output is not stalled, set by the shading pipe moving one stage per cycle.
// A four-word queue lets input and output stall independently.
// Reset clears the scan position, the queue and the pipe; registers take their defaults.
// Depends on psfpg_pkg, psfpg_front, psfpg_queue, psfpg_back.
`timescale 1ns / 1ps

module phase_shift_fringe_pattern_generator
    import psfpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] grey_value, [19:8] column, [31:20] row
    output logic        m_tlast,   // end_of_frame
    output logic [2:0]  m_tuser    // [1:0] frame_index, [2] end_of_sequence
);

    cfg_t        cfg_reg, cfg_next;
    logic        push, pop, q_empty, q_full;
    pixel_word_t push_word, head_word, out_word;
    logic [7:0]  grey_value;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_ORIENTATION:    cfg_next.orientation    = cfg_data[0];
                REG_PHASE_STEP:     cfg_next.phase_step     = cfg_data[PHASE_BITS-1:0];
                REG_MIN_BRIGHTNESS: cfg_next.min_brightness = cfg_data[7:0];
                REG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data[SIZE_BITS-1:0];
                REG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data[SIZE_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orientation    <= 1'b0;
            cfg_reg.phase_step     <= '0;
            cfg_reg.min_brightness <= '0;
            cfg_reg.frame_width    <= SIZE_BITS'(1024);
            cfg_reg.frame_height   <= SIZE_BITS'(768);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psfpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .restart    (s_tdata[0]),
        .queue_full (q_full),
        .push       (push),
        .push_word  (push_word)
    );

    psfpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    psfpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_word   (head_word),
        .queue_empty (q_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .grey_value  (grey_value),
        .out_word    (out_word)
    );

    assign m_tdata = {out_word.row, out_word.column, grey_value};
    assign m_tlast = out_word.eof;
    assign m_tuser = {out_word.eos, out_word.frame};

endmodule

>>> rtl/psfpg_front.sv
// Scan counters: takes input words, tracks column, row and frame, tags frame ends.
// Depends on psfpg_pkg.
`timescale 1ns / 1ps

module psfpg_front
    import psfpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic        queue_full,
    output logic        push,
    output pixel_word_t push_word
);

    logic [SIDE_BITS-1:0] column_reg, column_next;
    logic [SIDE_BITS-1:0] row_reg, row_next;
    logic [1:0]           frame_reg, frame_next;

    logic [SIZE_BITS-1:0] width, height;
    logic [SIDE_BITS-1:0] col_cur, row_cur;
    logic [1:0]           frame_cur;
    logic [SIZE_BITS-1:0] col_inc, row_inc;
    logic [1:0]           frame_inc;
    logic                 col_wrap, row_wrap;

    function automatic logic [SIZE_BITS-1:0] clamp_side(input logic [SIZE_BITS-1:0] s);
        if (s == '0)
            return SIZE_BITS'(1);
        else if (s > SIZE_BITS'(MAX_SIDE))
            return SIZE_BITS'(MAX_SIDE);
        else
            return s;
    endfunction

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        width     = clamp_side(cfg.frame_width);
        height    = clamp_side(cfg.frame_height);
        col_cur   = restart ? '0 : column_reg;
        row_cur   = restart ? '0 : row_reg;
        frame_cur = restart ? FRAME_SINE : frame_reg;
        col_inc   = SIZE_BITS'(col_cur) + SIZE_BITS'(1);
        row_inc   = SIZE_BITS'(row_cur) + SIZE_BITS'(1);
        frame_inc = frame_cur + 2'd1;
        col_wrap  = col_inc >= width;
        row_wrap  = row_inc >= height;

        push_word.column = col_cur;
        push_word.row    = row_cur;
        push_word.frame  = frame_cur;
        push_word.eof    = col_wrap && row_wrap;
        push_word.eos    = col_wrap && row_wrap && (frame_cur >= FRAME_FLAT);

        column_next = column_reg;
        row_next    = row_reg;
        frame_next  = frame_reg;
        if (push)
        begin
            column_next = col_wrap ? '0 : col_inc[SIDE_BITS-1:0];
            row_next    = row_cur;
            frame_next  = frame_cur;
            if (col_wrap)
            begin
                row_next = row_wrap ? '0 : row_inc[SIDE_BITS-1:0];
                if (row_wrap)
                begin
                    frame_next = (frame_inc >= FRAME_COUNT) ? FRAME_SINE : frame_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            frame_reg  <= FRAME_SINE;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            frame_reg  <= frame_next;
        end
    end

    a_eos_on_flat_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_word.eos |-> push_word.eof && push_word.frame == FRAME_FLAT)
        else $error("end of sequence outside the last flat pixel");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg != FRAME_COUNT)
        else $error("frame counter out of range");

endmodule

>>> rtl/psfpg_queue.sv
// Four-word queue between the scan counters and the shading pipe.
// Depends on psfpg_pkg.
`timescale 1ns / 1ps

module psfpg_queue
    import psfpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pixel_word_t push_word,
    input  logic        pop,
    output pixel_word_t head_word,
    output logic        empty,
    output logic        full
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    pixel_word_t           slot_reg [0:DEPTH-1];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign empty     = count_reg == '0;
    assign full      = count_reg == CNT_BITS'(DEPTH);
    assign head_word = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("write into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("read from an empty queue");

endmodule

>>> rtl/psfpg_back.sv
// Shading pipe: phase multiply, sine lookup, brightness scale, output register.
// Depends on psfpg_pkg (sine table, types).
`timescale 1ns / 1ps

module psfpg_back
    import psfpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  pixel_word_t head_word,
    input  logic        queue_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  grey_value,
    output pixel_word_t out_word
);

    localparam int PROD_BITS = POS_BITS + PHASE_BITS;

    logic                  a_vld_reg, b_vld_reg, o_vld_reg;
    logic [TABLE_BITS-1:0] a_idx_reg;
    logic                  a_flat_reg;
    pixel_word_t           a_word_reg, b_word_reg, o_word_reg;
    logic [LEVEL_BITS-1:0] b_level_reg;
    logic [7:0]            o_grey_reg;

    logic                  advance;
    logic [POS_BITS-1:0]   pos;
    logic [PROD_BITS-1:0]  phase_prod;
    logic [TABLE_BITS-1:0] idx_base, idx_next;
    logic [1:0]            quad;
    logic [ADDR_BITS-1:0]  q_part, q_addr;
    logic [SINE_BITS-1:0]  sine_mag;
    logic [LEVEL_BITS-1:0] level_next;
    logic [GAIN_BITS-1:0]  gain;
    logic [LEVEL_BITS+GAIN_BITS-1:0] scaled;
    logic [9:0]            grey_sum;
    logic [7:0]            grey_next;

    // the whole pipe moves whenever the output word is free or being taken
    assign advance    = !o_vld_reg || out_ready;
    assign pop        = advance && !queue_empty;
    assign out_valid  = o_vld_reg;
    assign grey_value = o_grey_reg;
    assign out_word   = o_word_reg;

    always_comb
    begin
        pos        = cfg.orientation ? head_word.row : head_word.column;
        phase_prod = PROD_BITS'(pos) * PROD_BITS'(cfg.phase_step);
        idx_base   = phase_prod[PHASE_BITS-1 -: TABLE_BITS];
        idx_next   = (head_word.frame == FRAME_COSINE) ?
                     idx_base + TABLE_BITS'(QSIZE) : idx_base;

        // fold the quadrant onto the quarter table
        quad     = a_idx_reg[TABLE_BITS-1 -: 2];
        q_part   = {1'b0, a_idx_reg[TABLE_BITS-3:0]};
        q_addr   = quad[0] ? ADDR_BITS'(QSIZE) - q_part : q_part;
        sine_mag = SINE_TABLE[q_addr];
        if (a_flat_reg)
            level_next = LEVEL_BITS'(Q16_ONE);
        else if (quad[1])
            level_next = LEVEL_BITS'(Q16_ONE) - LEVEL_BITS'(sine_mag);
        else
            level_next = LEVEL_BITS'(Q16_ONE) + LEVEL_BITS'(sine_mag);

        gain     = GAIN_BITS'(256) - GAIN_BITS'(cfg.min_brightness);
        scaled   = (LEVEL_BITS+GAIN_BITS)'(b_level_reg) * (LEVEL_BITS+GAIN_BITS)'(gain);
        grey_sum = 10'(scaled[LEVEL_BITS+GAIN_BITS-1:LEVEL_BITS-1])
                 + 10'(cfg.min_brightness);
        grey_next = (grey_sum >= 10'd256) ? 8'd255 : grey_sum[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idx_reg   <= idx_next;
            a_flat_reg  <= head_word.frame == FRAME_FLAT;
            a_word_reg  <= head_word;
            b_level_reg <= level_next;
            b_word_reg  <= a_word_reg;
            o_grey_reg  <= grey_next;
            o_word_reg  <= b_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg <= !queue_empty;
            b_vld_reg <= a_vld_reg;
            o_vld_reg <= b_vld_reg;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        o_vld_reg && !out_ready |=> o_vld_reg && $stable(o_grey_reg) && $stable(o_word_reg))
        else $error("output word changed while stalled");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        o_vld_reg && !out_ready |-> !pop)
        else $error("queue read while the pipe is stalled");

endmodule
